// ===== rtl/lps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper package
// Shared widths, codes and item types of the Bresenham line stepper.
// ----------------------------------------------------------------------------
package lps_pkg;

   // Coordinate width of the end points and of the stepped pixel.
   localparam int COORD_BITS = 16;
   // A span (absolute delta) needs one more bit than a coordinate.
   localparam int SPAN_BITS  = COORD_BITS + 1;
   // The error term swings between about -2*major and +2*minor.
   localparam int ERR_BITS   = COORD_BITS + 4;
   // Screen size registers.
   localparam int DIM_BITS   = 13;
   localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int COLOR_BITS = 32;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = DIM_BITS;
   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(1024);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(768);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   // Kind of input item.
   typedef enum logic {
      REQ_LOAD = 1'b0,
      REQ_STEP = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic                         req_type;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic [COLOR_BITS-1:0]        line_color;
   } lps_req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] pixel_x;
      logic signed [COORD_BITS-1:0] pixel_y;
      logic [COLOR_BITS-1:0]        pixel_color;
      logic                         on_screen;
      logic                         last_pixel;
   } lps_rsp_type;

   // Stepper state carried between the setup, step and register parts.
   typedef struct packed {
      logic                         active;
      logic signed [COORD_BITS-1:0] cur_x;
      logic signed [COORD_BITS-1:0] cur_y;
      logic signed [ERR_BITS-1:0]   err_term;
      logic [SPAN_BITS-1:0]         major_span;
      logic [SPAN_BITS-1:0]         minor_span;
      logic [SPAN_BITS-1:0]         steps_left;
      logic                         x_major;
      logic                         x_negative;
      logic                         y_negative;
      logic [COLOR_BITS-1:0]        held_color;
   } lps_state_type;

endpackage

// ===== rtl/line_pixel_stepper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper core
// Bresenham line stepper: a load item sets up a line, each step item emits
// the next pixel with its colour, on-screen flag and last flag.
// ----------------------------------------------------------------------------
// Output: the pixel of an accepted step item is held in the output register
// and presented on the rsp channel from there.
// Throughput: one item per cycle unless the rsp channel stalls; the step logic
// is combinational, between the state registers and the output register.
// Reset (synchronous, active high): the stepper goes idle, no item is held,
// screen width returns to 1024 and screen height to 768.
module line_pixel_stepper_core (
   input  logic                                clock,
   input  logic                                reset,
   // Input items.
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lps_pkg::lps_req_type                req_data,
   // Result items.
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lps_pkg::lps_rsp_type                rsp_data,
   // Configuration writes.
   input  logic                                csr_write_en,
   input  logic [lps_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lps_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import lps_pkg::*;

   lps_state_type         state_ff;
   lps_state_type         state_in;
   lps_state_type         init_state;
   lps_state_type         step_state;
   lps_rsp_type           step_pixel;
   lps_rsp_type           rsp_data_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DIM_BITS-1:0]   width_ff;
   logic [DIM_BITS-1:0]   height_ff;
   logic                  req_fire;
   logic                  is_load;
   logic                  emit;

   // Setup of a new line from a load item.
   lps_setup u_setup (
      .req        (req_data),
      .init_state (init_state)
   );

   // One pixel step from the current state.
   lps_step u_step (
      .cur_state     (state_ff),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .next_state    (step_state),
      .pixel         (step_pixel)
   );

   // An item is taken whenever the output register is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_load   = req_data.req_type == REQ_LOAD;
   assign emit      = req_fire && !is_load && state_ff.active;

   // Next stepper state.
   always_comb begin
      state_in = state_ff;
      if (req_fire && is_load) begin
         state_in = init_state;
      end else if (emit) begin
         state_in = step_state;
      end
   end

   // Output valid: set by an emitted pixel, cleared when the item is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= step_pixel;
      end
   end

   // Screen size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SCREEN_WIDTH: begin
               width_ff <= csr_wdata;
            end
            CSR_SCREEN_HEIGHT: begin
               height_ff <= csr_wdata;
            end
            default: begin
               width_ff <= width_ff;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A load item never leaves a result behind it.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_load |=> !rsp_valid_ff)
      else $error("load item produced a result");

   // A step while idle produces nothing and keeps the stepper idle.
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_load && !state_ff.active |=> !rsp_valid_ff && !state_ff.active)
      else $error("step while idle changed the stepper");

   // The pixel flagged last ends the line.
   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      emit && step_pixel.last_pixel |=> !state_ff.active)
      else $error("line still active after its last pixel");

   // An active line always has steps left.
   a_active_steps: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> state_ff.steps_left != '0)
      else $error("active line with no steps left");

   // An emitted pixel is presented in the next cycle with its payload.
   a_emit_shown: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff && rsp_data_ff == $past(step_pixel))
      else $error("emitted pixel not presented");

endmodule

// ===== rtl/lps_setup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper setup
// Turns a load item into the initial stepper state: deltas, major axis,
// spans and the initial error term.
// ----------------------------------------------------------------------------
module lps_setup (
   input  lps_pkg::lps_req_type   req,
   output lps_pkg::lps_state_type init_state
);
   import lps_pkg::*;

   logic signed [SPAN_BITS-1:0] dx;
   logic signed [SPAN_BITS-1:0] dy;
   logic [SPAN_BITS-1:0]        ax;
   logic [SPAN_BITS-1:0]        ay;
   logic                        x_major;
   logic [SPAN_BITS-1:0]        major_span;
   logic [SPAN_BITS-1:0]        minor_span;

   // Signed deltas, one bit wider than a coordinate so they cannot wrap.
   assign dx = SPAN_BITS'(req.end_x) - SPAN_BITS'(req.start_x);
   assign dy = SPAN_BITS'(req.end_y) - SPAN_BITS'(req.start_y);

   // Absolute deltas and the choice of major axis.
   assign ax = dx[SPAN_BITS-1] ? unsigned'(-dx) : unsigned'(dx);
   assign ay = dy[SPAN_BITS-1] ? unsigned'(-dy) : unsigned'(dy);
   assign x_major    = ax > ay;
   assign major_span = x_major ? ax : ay;
   assign minor_span = x_major ? ay : ax;

   // Initial state; a zero-length line leaves the stepper idle.
   always_comb begin
      init_state            = '0;
      init_state.active     = major_span != '0;
      init_state.cur_x      = req.start_x;
      init_state.cur_y      = req.start_y;
      init_state.err_term   = signed'(ERR_BITS'({minor_span, 1'b0}))
                              - signed'(ERR_BITS'(major_span));
      init_state.major_span = major_span;
      init_state.minor_span = minor_span;
      init_state.steps_left = major_span;
      init_state.x_major    = x_major;
      init_state.x_negative = dx[SPAN_BITS-1];
      init_state.y_negative = dy[SPAN_BITS-1];
      init_state.held_color = req.line_color;
   end

endmodule

// ===== rtl/lps_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper step logic
// Advances the current state by one pixel and forms the result item with
// its clipping and last flags.
// ----------------------------------------------------------------------------
module lps_step (
   input  lps_pkg::lps_state_type       cur_state,
   input  logic [lps_pkg::DIM_BITS-1:0] screen_width,
   input  logic [lps_pkg::DIM_BITS-1:0] screen_height,
   output lps_pkg::lps_state_type       next_state,
   output lps_pkg::lps_rsp_type         pixel
);
   import lps_pkg::*;

   logic                         minor_move;
   logic                         move_x;
   logic                         move_y;
   logic signed [COORD_BITS-1:0] step_x;
   logic signed [COORD_BITS-1:0] step_y;
   logic signed [COORD_BITS-1:0] next_x;
   logic signed [COORD_BITS-1:0] next_y;
   logic signed [ERR_BITS-1:0]   two_minor;
   logic signed [ERR_BITS-1:0]   two_major;
   logic                         last;
   logic                         x_visible;
   logic                         y_visible;

   // The major axis always moves; the minor axis moves when the error is not
   // negative.
   assign minor_move = !cur_state.err_term[ERR_BITS-1];
   assign move_x     = cur_state.x_major || minor_move;
   assign move_y     = !cur_state.x_major || minor_move;

   // Unit steps in the direction of the line.
   assign step_x = cur_state.x_negative ? '1 : COORD_BITS'(1);
   assign step_y = cur_state.y_negative ? '1 : COORD_BITS'(1);
   assign next_x = move_x ? cur_state.cur_x + step_x : cur_state.cur_x;
   assign next_y = move_y ? cur_state.cur_y + step_y : cur_state.cur_y;

   // Error term update.
   assign two_minor = signed'(ERR_BITS'({cur_state.minor_span, 1'b0}));
   assign two_major = signed'(ERR_BITS'({cur_state.major_span, 1'b0}));

   // The line ends when the last remaining step is taken.
   assign last = cur_state.steps_left <= SPAN_BITS'(1);

   // Clipping against the configured screen size.
   assign x_visible = !next_x[COORD_BITS-1]
                      && (CMP_BITS'(unsigned'(next_x)) < CMP_BITS'(screen_width));
   assign y_visible = !next_y[COORD_BITS-1]
                      && (CMP_BITS'(unsigned'(next_y)) < CMP_BITS'(screen_height));

   // Next state.
   always_comb begin
      next_state            = cur_state;
      next_state.cur_x      = next_x;
      next_state.cur_y      = next_y;
      next_state.err_term   = cur_state.err_term + two_minor
                              - (minor_move ? two_major : '0);
      next_state.steps_left = cur_state.steps_left - SPAN_BITS'(1);
      next_state.active     = !last;
   end

   // Result item.
   always_comb begin
      pixel.pixel_x     = next_x;
      pixel.pixel_y     = next_y;
      pixel.pixel_color = cur_state.held_color;
      pixel.on_screen   = x_visible && y_visible;
      pixel.last_pixel  = last;
   end

endmodule

// ===== test/tb_line_pixel_stepper_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line pixel stepper core testbench
// Drives load and step items into the stepper under random backpressure on
// both channels. A behavioral tracer follows the line from each load and
// predicts every pixel, which is then compared field by field with the
// pixels that come out. A short table of hand-written items comes first.
// Random line traces follow under several screen sizes.
// ----------------------------------------------------------------------------
module tb_line_pixel_stepper_core;
   import lps_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_ITEMS = 235;
   localparam int REQ_BITS    = $bits(lps_req_type);

   // How a table row's outcome is checked.
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_NONE,
      CHECK_PIXEL
   } check_kind_type;

   typedef struct {
      lps_req_type    item;
      check_kind_type kind;
      lps_rsp_type    pix;
   } dir_row_type;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   lps_req_type               req_data;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   lps_rsp_type               rsp_data;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   // Check tag that travels with the item on the req channel.
   check_kind_type req_kind;
   lps_rsp_type    req_pix;

   int req_idle_pct;
   int rsp_stall_pct;
   int fail_count   = 0;
   int useful_count = 0;
   int quiet_cycles = 0;

   lps_rsp_type pixel_q[$];
   dir_row_type dir_rows[$];

   // Tracer state, kept at the block's widths.
   logic                         trace_active = 1'b0;
   logic signed [COORD_BITS-1:0] trace_x      = '0;
   logic signed [COORD_BITS-1:0] trace_y      = '0;
   logic signed [ERR_BITS-1:0]   trace_err    = '0;
   logic [SPAN_BITS-1:0]         trace_major  = '0;
   logic [SPAN_BITS-1:0]         trace_minor  = '0;
   logic [SPAN_BITS-1:0]         trace_left   = '0;
   logic                         trace_xmajor = 1'b0;
   logic                         trace_xneg   = 1'b0;
   logic                         trace_yneg   = 1'b0;
   logic [COLOR_BITS-1:0]        trace_color  = '0;
   logic [DIM_BITS-1:0]          scr_width;
   logic [DIM_BITS-1:0]          scr_height;

   line_pixel_stepper_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #1 clock = ~clock;

   // Advance the traced line by one item; returns 1 when a pixel comes out.
   function automatic bit trace_pixel(input lps_req_type it, output lps_rsp_type pix);
      int sx, sy, dx, dy, ax, ay, mj, mn, e, x, y;
      bit last, on;
      pix = '0;
      if (it.req_type == REQ_LOAD) begin
         sx = it.start_x;
         sy = it.start_y;
         dx = int'(it.end_x) - sx;
         dy = int'(it.end_y) - sy;
         ax = (dx < 0) ? -dx : dx;
         ay = (dy < 0) ? -dy : dy;
         trace_x      = COORD_BITS'(sx);
         trace_y      = COORD_BITS'(sy);
         trace_xneg   = dx < 0;
         trace_yneg   = dy < 0;
         trace_color  = it.line_color;
         trace_xmajor = ax > ay;
         mj = trace_xmajor ? ax : ay;
         mn = trace_xmajor ? ay : ax;
         trace_major  = SPAN_BITS'(mj);
         trace_minor  = SPAN_BITS'(mn);
         trace_err    = ERR_BITS'(2 * mn - mj);
         trace_left   = SPAN_BITS'(mj);
         trace_active = mj != 0;
         return 1'b0;
      end
      if (!trace_active) return 1'b0;

      e  = trace_err;
      mj = trace_major;
      mn = trace_minor;
      x  = trace_x;
      y  = trace_y;
      // Major axis always moves; the minor axis moves when the error is not negative.
      if (trace_xmajor) x += trace_xneg ? -1 : 1;
      else y += trace_yneg ? -1 : 1;
      if (e >= 0) begin
         if (trace_xmajor) y += trace_yneg ? -1 : 1;
         else x += trace_xneg ? -1 : 1;
         e += 2 * mn - 2 * mj;
      end else begin
         e += 2 * mn;
      end
      trace_x    = COORD_BITS'(x);
      trace_y    = COORD_BITS'(y);
      trace_err  = ERR_BITS'(e);
      trace_left = trace_left - 1'b1;
      last = trace_left == '0;
      if (last) trace_active = 1'b0;
      on = x >= 0 && x < int'(scr_width) && y >= 0 && y < int'(scr_height);

      pix.pixel_x     = trace_x;
      pix.pixel_y     = trace_y;
      pix.pixel_color = trace_color;
      pix.on_screen   = on;
      pix.last_pixel  = last;
      return 1'b1;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] clamp_coord(input int v);
      if (v > 32767) return COORD_BITS'(32767);
      if (v < -32768) return COORD_BITS'(-32768);
      return COORD_BITS'(v);
   endfunction

   // Table row builders: a load, a step checked as given, a step with a typed pixel.
   function automatic dir_row_type ld(input int sx, sy, ex, ey, input logic [31:0] col);
      dir_row_type r;
      r.item            = '0;
      r.item.req_type   = REQ_LOAD;
      r.item.start_x    = COORD_BITS'(sx);
      r.item.start_y    = COORD_BITS'(sy);
      r.item.end_x      = COORD_BITS'(ex);
      r.item.end_y      = COORD_BITS'(ey);
      r.item.line_color = col;
      r.kind            = CHECK_NONE;
      r.pix             = '0;
      return r;
   endfunction

   function automatic dir_row_type st(input check_kind_type kind);
      dir_row_type r;
      r.item          = '0;
      r.item.req_type = REQ_STEP;
      r.kind          = kind;
      r.pix           = '0;
      return r;
   endfunction

   function automatic dir_row_type px(input int x, y, input logic [31:0] col,
                                      input logic on, last);
      dir_row_type r;
      r = st(CHECK_PIXEL);
      r.pix.pixel_x     = COORD_BITS'(x);
      r.pix.pixel_y     = COORD_BITS'(y);
      r.pix.pixel_color = col;
      r.pix.on_screen   = on;
      r.pix.last_pixel  = last;
      return r;
   endfunction

   // Present one item, idling at random first, and wait until it is accepted.
   task automatic drive_item(input lps_req_type it, input check_kind_type kind,
                             input lps_rsp_type lit);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= it;
      req_kind  <= kind;
      req_pix   <= lit;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Wait until every pixel has come out and the block has settled.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_screen(input logic [DIM_BITS-1:0] w, h);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SCREEN_WIDTH;
      csr_wdata    <= w;
      @(negedge clock);
      csr_index    <= CSR_SCREEN_HEIGHT;
      csr_wdata    <= h;
      @(negedge clock);
      csr_write_en <= 1'b0;
      scr_width  = w;
      scr_height = h;
   endtask

   // Pick a coordinate from one of several regions of interest.
   function automatic int pick_coord(input int dim);
      case ($urandom_range(0, 5))
         0: return $signed(16'($urandom));
         1: return int'($urandom_range(0, dim + 4)) - 2;
         2: return dim + int'($urandom_range(0, 8)) - 4;
         3: return int'($urandom_range(0, 16)) - 8;
         4: return $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 6))
                                         : -32768 + int'($urandom_range(0, 6));
         default: return int'($urandom_range(0, 2000)) - 500;
      endcase
   endfunction

   function automatic int pick_delta;
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return int'($urandom_range(0, 24)) - 12;
      if (r < 9) return int'($urandom_range(0, 600)) - 300;
      return $signed(16'($urandom));
   endfunction

   // Random line traces: mostly a load followed by its steps, some noise items.
   task automatic run_phase(input int target);
      lps_req_type  it;
      lps_rsp_type  none;
      logic [127:0] raw;
      int start_count, sx, sy, span, dx, dy, n;
      start_count = useful_count;
      none = '0;
      while (useful_count - start_count < target) begin
         if ($urandom_range(0, 9) < 8) begin
            sx = pick_coord(int'(scr_width));
            sy = pick_coord(int'(scr_height));
            it.req_type   = REQ_LOAD;
            it.start_x    = clamp_coord(sx);
            it.start_y    = clamp_coord(sy);
            it.end_x      = clamp_coord(sx + pick_delta());
            it.end_y      = clamp_coord(sy + pick_delta());
            it.line_color = $urandom;
            drive_item(it, CHECK_MODEL, none);
            dx = int'(it.end_x) - int'(it.start_x);
            dy = int'(it.end_y) - int'(it.start_y);
            dx = (dx < 0) ? -dx : dx;
            dy = (dy < 0) ? -dy : dy;
            span = (dx > dy) ? dx : dy;
            // Short lines run past their end; long or cut lines stop early.
            if (span > 40 || $urandom_range(0, 9) == 0) n = $urandom_range(0, 40);
            else n = span + $urandom_range(0, 2);
            repeat (n) begin
               raw = {$urandom, $urandom, $urandom, $urandom};
               it  = raw[REQ_BITS-1:0];
               it.req_type = REQ_STEP;
               drive_item(it, CHECK_MODEL, none);
            end
         end else begin
            raw = {$urandom, $urandom, $urandom, $urandom};
            it  = raw[REQ_BITS-1:0];
            it.req_type = $urandom_range(0, 1) ? REQ_STEP : REQ_LOAD;
            drive_item(it, CHECK_MODEL, none);
         end
      end
   endtask

   task automatic check_pixel(input lps_rsp_type exp_pix, input lps_rsp_type got);
      if (got.pixel_x !== exp_pix.pixel_x) begin
         $error("pixel_x expected %0d got %0d", exp_pix.pixel_x, got.pixel_x);
         fail_count++;
      end
      if (got.pixel_y !== exp_pix.pixel_y) begin
         $error("pixel_y expected %0d got %0d", exp_pix.pixel_y, got.pixel_y);
         fail_count++;
      end
      if (got.pixel_color !== exp_pix.pixel_color) begin
         $error("pixel_color expected %h got %h", exp_pix.pixel_color, got.pixel_color);
         fail_count++;
      end
      if (got.on_screen !== exp_pix.on_screen) begin
         $error("on_screen expected %b got %b", exp_pix.on_screen, got.on_screen);
         fail_count++;
      end
      if (got.last_pixel !== exp_pix.last_pixel) begin
         $error("last_pixel expected %b got %b", exp_pix.last_pixel, got.last_pixel);
         fail_count++;
      end
   endtask

   // Receiver: stall at random on every falling edge.
   always @(negedge clock) begin
      rsp_ready <= $urandom_range(0, 99) >= rsp_stall_pct;
   end

   // Accepted items feed the tracer; accepted pixels are checked in order.
   always @(posedge clock) begin : monitor
      lps_rsp_type traced;
      bit          got;
      if (!reset) begin
         if (req_valid && req_ready) begin
            got = trace_pixel(req_data, traced);
            if (req_data.req_type == REQ_LOAD || got) useful_count++;
            case (req_kind)
               CHECK_PIXEL: pixel_q.push_back(req_pix);
               CHECK_MODEL: if (got) pixel_q.push_back(traced);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pixel_q.size() == 0) begin
               $error("unexpected pixel x=%0d y=%0d", rsp_data.pixel_x, rsp_data.pixel_y);
               fail_count++;
            end else begin
               check_pixel(pixel_q.pop_front(), rsp_data);
            end
         end
         // Watchdog on cycles with no traffic on either channel.
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("line_pixel_stepper_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      req_kind      = CHECK_MODEL;
      req_pix       = '0;
      csr_write_en  = 1'b0;
      csr_index     = CSR_SCREEN_WIDTH;
      csr_wdata     = '0;
      req_idle_pct  = 18;
      rsp_stall_pct = 70;
      scr_width     = DIM_BITS'(1024);
      scr_height    = DIM_BITS'(768);

      // Directed table, run at the reset screen size of 1024 by 768.
      dir_rows.push_back(st(CHECK_NONE));                          // step while idle
      dir_rows.push_back(ld(0, 0, 3, 0, 32'hFFFF_FFFF));
      dir_rows.push_back(px(1, 0, 32'hFFFF_FFFF, 1'b1, 1'b0));
      dir_rows.push_back(px(2, 0, 32'hFFFF_FFFF, 1'b1, 1'b0));
      dir_rows.push_back(px(3, 0, 32'hFFFF_FFFF, 1'b1, 1'b1));
      dir_rows.push_back(st(CHECK_NONE));                          // past the end
      dir_rows.push_back(ld(5, 5, 5, 5, 32'h0000_1234));           // zero length
      dir_rows.push_back(st(CHECK_NONE));
      dir_rows.push_back(ld(-32768, -32768, 32767, 32767, 32'h0));
      dir_rows.push_back(px(-32767, -32767, 32'h0, 1'b0, 1'b0));
      dir_rows.push_back(px(-32766, -32766, 32'h0, 1'b0, 1'b0));
      // Load over an active line replaces it.
      dir_rows.push_back(ld(32767, -32768, -32768, 32767, 32'h8000_0001));
      dir_rows.push_back(px(32766, -32767, 32'h8000_0001, 1'b0, 1'b0));
      dir_rows.push_back(ld(1022, 766, 1024, 768, 32'hA5A5_A5A5));
      dir_rows.push_back(px(1023, 767, 32'hA5A5_A5A5, 1'b1, 1'b0));
      dir_rows.push_back(px(1024, 768, 32'hA5A5_A5A5, 1'b0, 1'b1));
      dir_rows.push_back(ld(-1, 0, 0, 0, 32'h5A5A_5A5A));
      dir_rows.push_back(px(0, 0, 32'h5A5A_5A5A, 1'b1, 1'b1));
      dir_rows.push_back(ld(10, 10, 13, 20, 32'h00C0_FFEE));
      repeat (3) dir_rows.push_back(st(CHECK_MODEL));
      dir_rows.push_back(ld(5, 0, -5, 3, 32'h0F0F_0F0F));
      repeat (3) dir_rows.push_back(st(CHECK_MODEL));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) drive_item(dir_rows[i].item, dir_rows[i].kind, dir_rows[i].pix);

      // Random phases, each under its own screen size and one of three idling patterns.
      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: set_screen(DIM_BITS'(0), DIM_BITS'(768));
            1: set_screen(DIM_BITS'(4096), DIM_BITS'(4096));
            2: set_screen(DIM_BITS'(1), DIM_BITS'(1));
            3: set_screen(DIM_BITS'(8191), DIM_BITS'(0));
            4: set_screen(DIM_BITS'(640), DIM_BITS'(480));
            default: set_screen(DIM_BITS'(1024), DIM_BITS'(8191));
         endcase
         if (p < 2) begin
            req_idle_pct  = 18;
            rsp_stall_pct = 70;
         end else if (p < 4) begin
            req_idle_pct  = 70;
            rsp_stall_pct = 18;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         run_phase(PHASE_ITEMS);
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("line_pixel_stepper_core verification clean");
      end else begin
         $display("line_pixel_stepper_core verification failed");
      end
      $finish;
   end

endmodule
